@@ design/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ design/des_pkg.sv @@
package des_pkg;

	localparam int unsigned NumRounds = 16;
	localparam int unsigned HalfKeyBits = 28;
	localparam int unsigned BlockBits = 64;

	typedef logic [BlockBits-1:0] block_t;
	typedef logic [HalfKeyBits-1:0] half_key_t;
	typedef logic [31:0] half_blk_t;

	// Data and key state that one round cell hands to its neighbor.
	typedef struct packed {
		half_blk_t lft;
		half_blk_t rgt;
		half_key_t c;
		half_key_t d;
	} round_state_t;

	typedef logic [7:0] sel_t;

	localparam sel_t TabIp [64] = '{
		58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
		62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
		57,49,41,33,25,17,9,1,  59,51,43,35,27,19,11,3,
		61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7};
	localparam sel_t TabFp [64] = '{
		40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
		38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
		36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
		34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25};
	localparam sel_t TabE [48] = '{
		32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13,
		12,13,14,15,16,17, 16,17,18,19,20,21, 20,21,22,23,24,25,
		24,25,26,27,28,29, 28,29,30,31,32,1};
	localparam sel_t TabP [32] = '{
		16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
		2,8,24,14,32,27,3,9, 19,13,30,6,22,11,4,25};
	localparam sel_t TabPc1 [56] = '{
		57,49,41,33,25,17,9, 1,58,50,42,34,26,18,
		10,2,59,51,43,35,27, 19,11,3,60,52,44,36,
		63,55,47,39,31,23,15, 7,62,54,46,38,30,22,
		14,6,61,53,45,37,29, 21,13,5,28,20,12,4};
	localparam sel_t TabPc2 [48] = '{
		14,17,11,24,1,5, 3,28,15,6,21,10,
		23,19,12,4,26,8, 16,7,27,20,13,2,
		41,52,31,37,47,55, 30,40,51,45,33,48,
		44,49,39,56,34,53, 46,42,50,36,29,32};

	typedef logic [3:0] nib_t;
	localparam nib_t TabSbox [8][64] = '{
		'{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7,
		  0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
		  4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0,
		  15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
		'{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10,
		  3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
		  0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15,
		  13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
		'{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8,
		  13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
		  13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7,
		  1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
		'{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15,
		  13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
		  10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4,
		  3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
		'{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9,
		  14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
		  4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14,
		  11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
		'{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11,
		  10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
		  9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6,
		  4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
		'{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1,
		  13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
		  1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2,
		  6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
		'{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7,
		  1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
		  7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8,
		  2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

	// Left rotation amount of the key halves, per round.
	localparam logic [1:0] TabRot [16] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};

	// Output bit k from the MSB is input bit sel[k] (1-based from the MSB).
	function automatic block_t perm_ip(block_t src);
		block_t acc;
		for (int k = 0; k < 64; k++) acc[63-k] = src[64-int'(TabIp[k])];
		return acc;
	endfunction

	function automatic block_t perm_fp(block_t src);
		block_t acc;
		for (int k = 0; k < 64; k++) acc[63-k] = src[64-int'(TabFp[k])];
		return acc;
	endfunction

	function automatic logic [55:0] perm_pc1(block_t src);
		logic [55:0] acc;
		for (int k = 0; k < 56; k++) acc[55-k] = src[64-int'(TabPc1[k])];
		return acc;
	endfunction

	function automatic logic [47:0] perm_pc2(logic [55:0] src);
		logic [47:0] acc;
		for (int k = 0; k < 48; k++) acc[47-k] = src[56-int'(TabPc2[k])];
		return acc;
	endfunction

	function automatic half_key_t rot28(half_key_t v, logic [1:0] s);
		half_key_t r;
		if (s == 2'd2) r = {v[25:0], v[27:26]};
		else r = {v[26:0], v[27]};
		return r;
	endfunction

	function automatic half_blk_t round_fn(half_blk_t half, logic [47:0] rkey);
		logic [47:0] x;
		half_blk_t acc;
		half_blk_t res;
		logic [5:0] six;
		for (int k = 0; k < 48; k++) x[47-k] = half[32-int'(TabE[k])];
		x = x ^ rkey;
		for (int g = 0; g < 8; g++) begin
			six = x[47-6*g -: 6];
			acc[31-4*g -: 4] = TabSbox[g][{six[5], six[0], six[4:1]}];
		end
		for (int k = 0; k < 32; k++) res[31-k] = acc[32-int'(TabP[k])];
		return res;
	endfunction

endpackage

@@ design/des_round_cell.sv @@
module des_round_cell import des_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic [3:0]   round_idx,
	input  logic         vld_in,
	input  round_state_t st_in,
	output logic         vld_q,
	output round_state_t st_q
);

	half_key_t c_rot;
	half_key_t d_rot;
	logic [47:0] rkey;

	always_comb begin
		c_rot = rot28(st_in.c, TabRot[round_idx]);
		d_rot = rot28(st_in.d, TabRot[round_idx]);
		rkey = perm_pc2({c_rot, d_rot});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		st_q.lft <= st_in.rgt;
		st_q.rgt <= st_in.lft ^ round_fn(st_in.rgt, rkey);
		st_q.c <= c_rot;
		st_q.d <= d_rot;
	end

endmodule

@@ design/des_block_encrypt.sv @@
// Channel   Signals                         Direction  Handshake
// command   start, busy, plain_block        in         start & !busy
// result    done, cipher_block              out        done strobe, one cycle
// config    cfg_valid, cfg_ready, cfg_data  in         cfg_valid & cfg_ready
//
// One block is accepted every cycle; busy is never raised.
// A block passes through one entry register, sixteen round cells and one
// output register before its result appears.
// Reset clears the key and all valid flags; the result side cannot stall.
module des_block_encrypt import des_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   start,
	output logic   busy,
	input  block_t plain_block,
	output logic   done,
	output block_t cipher_block,
	input  logic   cfg_valid,
	output logic   cfg_ready,
	input  block_t cfg_data
);

	block_t key_q;
	logic vld_s1;
	round_state_t st_s1;
	logic [NumRounds:0] vld_chain;
	round_state_t st_chain [NumRounds+1];
	logic [55:0] cd;
	block_t ip_blk;

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
			vld_s1 <= 1'b0;
		end else begin
			if (cfg_valid) key_q <= cfg_data;
			vld_s1 <= start;
		end
	end

	// The entry stage applies IP and PC-1 so each cell only does one round.
	always_comb begin
		cd = perm_pc1(key_q);
		ip_blk = perm_ip(plain_block);
	end

	always_ff @(posedge clk) begin
		st_s1 <= '{lft: ip_blk[63:32], rgt: ip_blk[31:0],
			c: cd[55:28], d: cd[27:0]};
	end

	assign vld_chain[0] = vld_s1;
	assign st_chain[0] = st_s1;

	// The chain of round cells: each one takes its neighbor's state per cycle.
	for (genvar r = 0; r < NumRounds; r++) begin : g_round
		des_round_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.round_idx(4'(r)),
			.vld_in(vld_chain[r]),
			.st_in(st_chain[r]),
			.vld_q(vld_chain[r+1]),
			.st_q(st_chain[r+1])
		);
	end

	// Output register: halves are swapped, then the final permutation.
	logic done_q;
	block_t out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_chain[NumRounds];
		end
	end

	always_ff @(posedge clk) begin
		out_q <= perm_fp({st_chain[NumRounds].rgt, st_chain[NumRounds].lft});
	end

	assign done = done_q;
	assign cipher_block = out_q;

endmodule

@@ design/des_checker.sv @@
`include "assert_macros.svh"

module des_checker import des_pkg::*; (
	input logic   clk,
	input logic   arst_n,
	input logic   start,
	input logic   busy,
	input logic   done,
	input block_t cipher_block,
	input logic   cfg_valid,
	input logic   cfg_ready
);

	`ASSERT_IMPL(a_never_busy, clk, arst_n, 1'b1, !busy)
	`ASSERT_IMPL(a_cfg_ready, clk, arst_n, cfg_valid, cfg_ready)
	`ASSERT_IMPL(a_done_latency, clk, arst_n, $past(start && !busy, 18), done)
	`ASSERT_IMPL(a_no_spurious, clk, arst_n, done, $past(start, 18))
	`ASSERT_IMPL(a_result_known, clk, arst_n, done, !$isunknown(cipher_block))

endmodule

bind des_block_encrypt des_checker u_des_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.done(done),
	.cipher_block(cipher_block),
	.cfg_valid(cfg_valid),
	.cfg_ready(cfg_ready)
);
